// ===== rtl/core/xdre_pkg.sv =====
// ----------------------------------------------------------------------------
// xdre_pkg
// Shared types and constants for the XOR-delta run-length frame encoder.
// ----------------------------------------------------------------------------
package xdre_pkg;

  localparam int DATA_W          = 8;
  localparam int HDR_W           = 9;
  localparam int FRAME_BYTES_DEF = 8192;
  localparam int LITERAL_MAX_DEF = 16;

  // A repeat packet covers at most 255 copies, header -(n-1).
  localparam int REPEAT_LIMIT = -255;
  localparam logic signed [HDR_W-1:0] RUN_FLOOR = HDR_W'(REPEAT_LIMIT + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CODE,
    ST_FLUSH,
    ST_END,
    ST_HDR,
    ST_BUF,
    ST_TAIL
  } state_t;

  // Which packet of the current word is being sent.
  typedef enum logic [1:0] {
    PH_STEP,
    PH_FLUSH,
    PH_END
  } phase_t;

  typedef struct packed {
    logic capture;
    logic code;
    logic load_flush;
    logic load_end;
    logic push_hdr;
    logic push_buf;
    logic push_tail;
    logic mark_last;
  } cmd_t;

  typedef struct packed {
    logic code_job;
    logic last;
    logic nbuf_zero;
    logic buf_last;
    logic tail;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/xdre_ram.sv =====
// ----------------------------------------------------------------------------
// xdre_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module xdre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/xdre_ctrl.sv =====
// ----------------------------------------------------------------------------
// xdre_ctrl
// Controller: sequences the coding step, the packets it sends, the end of
// frame flush and the closing zero header.
// ----------------------------------------------------------------------------
module xdre_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  xdre_pkg::status_t st,
  output xdre_pkg::cmd_t    cmd
);

  import xdre_pkg::*;

  state_t state_r, state_nxt;
  phase_t ph_r, ph_nxt;
  logic   hdr_only;
  logic   buf_end;
  logic   final_job;
  state_t after_job;

  assign hdr_only  = st.nbuf_zero && !st.tail;
  assign buf_end   = st.buf_last && !st.tail;
  assign final_job = (ph_r == PH_END) || ((ph_r == PH_STEP) && !st.last);

  always_comb begin
    unique case (ph_r)
      PH_STEP:  after_job = st.last ? ST_FLUSH : ST_IDLE;
      PH_FLUSH: after_job = ST_END;
      default:  after_job = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= PH_STEP;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CODE;
        end
      end
      ST_CODE: begin
        ph_nxt = PH_STEP;
        if (st.code_job) begin
          state_nxt = ST_HDR;
        end else if (st.last) begin
          state_nxt = ST_FLUSH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        ph_nxt    = PH_FLUSH;
        state_nxt = ST_HDR;
      end
      ST_END: begin
        ph_nxt    = PH_END;
        state_nxt = ST_HDR;
      end
      ST_HDR: begin
        if (st.out_free) begin
          if (!st.nbuf_zero) begin
            state_nxt = ST_BUF;
          end else if (st.tail) begin
            state_nxt = ST_TAIL;
          end else begin
            state_nxt = after_job;
          end
        end
      end
      ST_BUF: begin
        if (st.out_free && st.buf_last) begin
          state_nxt = st.tail ? ST_TAIL : after_job;
        end
      end
      ST_TAIL: begin
        if (st.out_free) begin
          state_nxt = after_job;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_CODE:  cmd.code       = 1'b1;
      ST_FLUSH: cmd.load_flush = 1'b1;
      ST_END:   cmd.load_end   = 1'b1;
      ST_HDR: begin
        cmd.push_hdr  = st.out_free;
        cmd.mark_last = final_job && hdr_only;
      end
      ST_BUF: begin
        cmd.push_buf  = st.out_free;
        cmd.mark_last = final_job && buf_end;
      end
      ST_TAIL: begin
        cmd.push_tail = st.out_free;
        cmd.mark_last = final_job;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/xdre_dpath.sv =====
// ----------------------------------------------------------------------------
// xdre_dpath
// Datapath: frame history, delta forming, run-length state, literal buffer,
// packet job registers and the output register.
// ----------------------------------------------------------------------------
module xdre_dpath #(
  parameter int FRAME_BYTES = xdre_pkg::FRAME_BYTES_DEF,
  parameter int LITERAL_MAX = xdre_pkg::LITERAL_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic                               cfg_wdata,
  input  logic [xdre_pkg::DATA_W-1:0]        in_data_byte,
  input  logic                               in_frame_last,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic                               out_is_header,
  output logic signed [xdre_pkg::HDR_W-1:0]  out_header_run,
  output logic [xdre_pkg::DATA_W-1:0]        out_data_out,
  output logic                               out_last_of_step,
  input  xdre_pkg::cmd_t                     cmd,
  output xdre_pkg::status_t                  st
);

  import xdre_pkg::*;

  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam int CNT_W = $clog2(LITERAL_MAX + 1);
  localparam int IDX_W = $clog2(LITERAL_MAX);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(LITERAL_MAX);
  localparam logic signed [HDR_W-1:0] RUN_ONE = HDR_W'(1);

  // Control state
  logic                    xor_en_r;
  logic                    first_r, first_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic                    pv_r, pv_nxt;
  logic [DATA_W-1:0]       pend_r, pend_nxt;
  logic signed [HDR_W-1:0] run_r, run_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r;

  // Payload state
  logic [DATA_W-1:0]       raw_r;
  logic                    last_r;
  logic signed [HDR_W-1:0] job_hdr_r, job_hdr_nxt;
  logic [CNT_W-1:0]        job_nbuf_r, job_nbuf_nxt;
  logic                    job_tail_r, job_tail_nxt;
  logic [DATA_W-1:0]       job_byte_r, job_byte_nxt;
  logic [IDX_W-1:0]        buf_idx_r;
  logic                    out_is_header_r;
  logic signed [HDR_W-1:0] out_header_run_r;
  logic [DATA_W-1:0]       out_data_out_r;
  logic                    out_last_r;

  logic [DATA_W-1:0] hist_rdata;
  logic [DATA_W-1:0] lit_rdata;
  logic [DATA_W-1:0] delta;
  logic [CNT_W-1:0]  cnt_inc;
  logic              dup;
  logic c_seed, c_extend, c_rep_full, c_append, c_lit_full, c_rep_break, c_lit_dup;
  logic              lit_re;
  logic [IDX_W-1:0]  lit_raddr;

  // Previous frame history, read at the accept edge and rewritten in the code cycle.
  xdre_ram #(
    .WIDTH (DATA_W),
    .DEPTH (FRAME_BYTES)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.code),
    .waddr (pos_r),
    .wdata (raw_r),
    .re    (cmd.capture),
    .raddr (pos_r),
    .rdata (hist_rdata)
  );

  // Literal buffer. The header push prefetches entry 0, each data push the next.
  assign lit_re    = cmd.push_hdr || cmd.push_buf;
  assign lit_raddr = cmd.push_hdr ? '0 : IDX_W'(buf_idx_r + 1'b1);

  xdre_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LITERAL_MAX)
  ) u_lit (
    .clk   (clk),
    .we    (cmd.code && c_append),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (pend_r),
    .re    (lit_re),
    .raddr (lit_raddr),
    .rdata (lit_rdata)
  );

  assign delta   = (xor_en_r && !first_r) ? (raw_r ^ hist_rdata) : raw_r;
  assign dup     = (delta == pend_r);
  assign cnt_inc = cnt_r + 1'b1;

  // Coding decision for the current delta byte.
  assign c_seed      = !pv_r;
  assign c_extend    = pv_r && (run_r <= 0) && dup && (run_r > RUN_FLOOR);
  assign c_rep_full  = pv_r && (run_r <= 0) && dup && !(run_r > RUN_FLOOR);
  assign c_append    = pv_r && (run_r >= 0) && !dup && (cnt_inc < CNT_MAX);
  assign c_lit_full  = pv_r && (run_r >= 0) && !dup && !(cnt_inc < CNT_MAX);
  assign c_rep_break = pv_r && (run_r < 0) && !dup;
  assign c_lit_dup   = pv_r && (run_r > 0) && dup;

  always_comb begin
    first_nxt    = first_r;
    pos_nxt      = pos_r;
    pv_nxt       = pv_r;
    pend_nxt     = pend_r;
    run_nxt      = run_r;
    cnt_nxt      = cnt_r;
    job_hdr_nxt  = job_hdr_r;
    job_nbuf_nxt = job_nbuf_r;
    job_tail_nxt = job_tail_r;
    job_byte_nxt = job_byte_r;
    if (cmd.code) begin
      if (last_r) begin
        pos_nxt   = '0;
        first_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
      if (c_seed) begin
        pend_nxt = delta;
        pv_nxt   = 1'b1;
        run_nxt  = '0;
      end else if (c_extend) begin
        run_nxt = run_r - RUN_ONE;
      end else if (c_rep_full || c_rep_break) begin
        job_hdr_nxt  = run_r;
        job_nbuf_nxt = '0;
        job_tail_nxt = 1'b1;
        job_byte_nxt = pend_r;
        run_nxt      = '0;
        pend_nxt     = delta;
      end else if (c_append) begin
        cnt_nxt  = cnt_inc;
        run_nxt  = run_r + RUN_ONE;
        pend_nxt = delta;
      end else if (c_lit_full) begin
        // The pending byte closes the packet straight from its register.
        job_hdr_nxt  = HDR_W'(LITERAL_MAX);
        job_nbuf_nxt = cnt_r;
        job_tail_nxt = 1'b1;
        job_byte_nxt = pend_r;
        cnt_nxt      = '0;
        run_nxt      = '0;
        pend_nxt     = delta;
      end else if (c_lit_dup) begin
        job_hdr_nxt  = HDR_W'(cnt_r);
        job_nbuf_nxt = cnt_r;
        job_tail_nxt = 1'b0;
        cnt_nxt      = '0;
        run_nxt      = -RUN_ONE;
        pend_nxt     = delta;
      end
    end else if (cmd.load_flush) begin
      if (run_r < 0) begin
        job_hdr_nxt  = run_r;
        job_nbuf_nxt = '0;
      end else begin
        job_hdr_nxt  = HDR_W'(cnt_inc);
        job_nbuf_nxt = cnt_r;
      end
      job_tail_nxt = 1'b1;
      job_byte_nxt = pend_r;
    end else if (cmd.load_end) begin
      job_hdr_nxt  = '0;
      job_nbuf_nxt = '0;
      job_tail_nxt = 1'b0;
      pv_nxt       = 1'b0;
      pend_nxt     = '0;
      run_nxt      = '0;
      cnt_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_en_r    <= 1'b1;
      first_r     <= 1'b1;
      pos_r       <= '0;
      pv_r        <= 1'b0;
      pend_r      <= '0;
      run_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        xor_en_r <= cfg_wdata;
      end
      first_r <= first_nxt;
      pos_r   <= pos_nxt;
      pv_r    <= pv_nxt;
      pend_r  <= pend_nxt;
      run_r   <= run_nxt;
      cnt_r   <= cnt_nxt;
      if (cmd.push_hdr || cmd.push_buf || cmd.push_tail) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_r  <= in_data_byte;
      last_r <= in_frame_last || (pos_r == POS_LAST);
    end
    job_hdr_r  <= job_hdr_nxt;
    job_nbuf_r <= job_nbuf_nxt;
    job_tail_r <= job_tail_nxt;
    job_byte_r <= job_byte_nxt;
    if (cmd.push_hdr) begin
      buf_idx_r <= '0;
    end else if (cmd.push_buf) begin
      buf_idx_r <= IDX_W'(buf_idx_r + 1'b1);
    end
    if (cmd.push_hdr) begin
      out_is_header_r  <= 1'b1;
      out_header_run_r <= job_hdr_r;
      out_data_out_r   <= '0;
      out_last_r       <= cmd.mark_last;
    end else if (cmd.push_buf || cmd.push_tail) begin
      out_is_header_r  <= 1'b0;
      out_header_run_r <= '0;
      out_data_out_r   <= cmd.push_buf ? lit_rdata : job_byte_r;
      out_last_r       <= cmd.mark_last;
    end
  end

  assign st.code_job  = c_rep_full || c_lit_full || c_rep_break || c_lit_dup;
  assign st.last      = last_r;
  assign st.nbuf_zero = (job_nbuf_r == '0);
  assign st.buf_last  = ((CNT_W'(buf_idx_r) + 1'b1) == job_nbuf_r);
  assign st.tail      = job_tail_r;
  assign st.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_is_header    = out_is_header_r;
  assign out_header_run   = out_header_run_r;
  assign out_data_out     = out_data_out_r;
  assign out_last_of_step = out_last_r;

endmodule

// ===== rtl/core/xor_delta_rle_frame_encoder_core.sv =====
// ----------------------------------------------------------------------------
// xor_delta_rle_frame_encoder_core
// XOR-delta run-length encoder for fixed-length state frames.
// ----------------------------------------------------------------------------
// Bytes of a frame arrive on the in_ channel (valid/ready), frame_last on the
// final one. Each byte is XORed with the same byte of the previous frame
// (unless it is the first frame or cfg_we has written xor_enable as 0) and the
// delta stream is sent on the out_ channel as run-length packets, one header
// or payload word per transfer; a zero header closes each frame, and
// last_of_step marks the final word caused by an input byte.
// An input word passes two steps (accept, then history read and coding);
// each packet word it causes is then pushed into the output register, and
// a frame end adds the flush and end load states before their packets. The
// next byte is taken once every word of the previous one has entered the
// output register. The registered read of the frame history memory keeps
// accept and coding in separate states. If the receiver stalls, the output
// register holds its word and the block stops issuing further words until
// it is taken.
// Reset clears the coding state and restarts with a raw first frame; the
// frame history memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module xor_delta_rle_frame_encoder_core #(
  parameter int FRAME_BYTES = xdre_pkg::FRAME_BYTES_DEF,
  parameter int LITERAL_MAX = xdre_pkg::LITERAL_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [xdre_pkg::DATA_W-1:0]       in_data_byte,
  input  logic                              in_frame_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_is_header,
  output logic signed [xdre_pkg::HDR_W-1:0] out_header_run,
  output logic [xdre_pkg::DATA_W-1:0]       out_data_out,
  output logic                              out_last_of_step
);

  import xdre_pkg::*;

  cmd_t    cmd;
  status_t st;

  xdre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  xdre_dpath #(
    .FRAME_BYTES (FRAME_BYTES),
    .LITERAL_MAX (LITERAL_MAX)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_data_byte     (in_data_byte),
    .in_frame_last    (in_frame_last),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_is_header    (out_is_header),
    .out_header_run   (out_header_run),
    .out_data_out     (out_data_out),
    .out_last_of_step (out_last_of_step),
    .cmd              (cmd),
    .st               (st)
  );

endmodule
